// ===== src/smsw_pkg.sv =====
// ----------------------------------------------------------------------------
// smsw_pkg
// Register indexes and shared types of the sphere vertex warp.
// ----------------------------------------------------------------------------
package smsw_pkg;

    localparam int CFG_INDEX_WIDTH = 3;

    typedef logic [CFG_INDEX_WIDTH-1:0] t_cfg_index;

    localparam t_cfg_index CFG_CENTER_X = 3'd0;
    localparam t_cfg_index CFG_CENTER_Y = 3'd1;
    localparam t_cfg_index CFG_CENTER_Z = 3'd2;
    localparam t_cfg_index CFG_RADIUS   = 3'd3;
    localparam t_cfg_index CFG_SHIFT_X  = 3'd4;
    localparam t_cfg_index CFG_SHIFT_Y  = 3'd5;
    localparam t_cfg_index CFG_SHIFT_Z  = 3'd6;

endpackage

// ===== src/smoothstep_sphere_vertex_warp.sv =====
// ----------------------------------------------------------------------------
// smoothstep_sphere_vertex_warp
// Displaces vertices inside a sphere by a smoothstep-weighted shift vector.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with i_pos_x/y/z. A vertex transfers on
//   a rising edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with o_new_x/y/z and o_moved.
//   Config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and
//   i_cfg_data; o_cfg_ready is always high. Write only while the pipeline
//   is empty.
//   Pipeline: registers for difference, square and sum, then the square
//   root pipeline, the divider, and registers for the weight, the scaled
//   shift and the saturating add.
//   Throughput: one vertex per cycle while the output is not stalled, set
//   by the fully pipelined root and divider stages.
//   Reset: all valid bits and all config registers clear to zero.
//   Stall: while o_valid is high and i_stall is high the whole pipeline
//   holds and o_stall is raised; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module smoothstep_sphere_vertex_warp #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COORD_WIDTH-1:0] o_new_x,
    output logic signed [COORD_WIDTH-1:0] o_new_y,
    output logic signed [COORD_WIDTH-1:0] o_new_z,
    output logic                          o_moved,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  smsw_pkg::t_cfg_index          i_cfg_index,
    input  logic [COORD_WIDTH-1:0]        i_cfg_data
);

    localparam int W  = COORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int RW = W - 1;
    localparam int SQ = 2 * RW;
    localparam int SW = 2 * W + 2;
    localparam int PW = W + F + 2;
    localparam logic [F+1:0] THREE_ONE = (F+2)'(3) << F;
    localparam logic signed [W+1:0] SAT_MAX = (W+2)'((64'(1) << (W - 1)) - 64'(1));
    localparam logic signed [W+1:0] SAT_MIN = -SAT_MAX - (W+2)'(1);

    logic [W-1:0]  r_cfg_center [0:2];
    logic [W-1:0]  r_cfg_shift  [0:2];
    logic [RW-1:0] r_cfg_radius;
    logic [SQ-1:0] r_r2;

    logic en;

    assign o_cfg_ready = 1'b1;
    assign en          = !(o_valid && i_stall);
    assign o_stall     = o_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_center[0] <= '0;
            r_cfg_center[1] <= '0;
            r_cfg_center[2] <= '0;
            r_cfg_shift[0]  <= '0;
            r_cfg_shift[1]  <= '0;
            r_cfg_shift[2]  <= '0;
            r_cfg_radius    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                smsw_pkg::CFG_CENTER_X: r_cfg_center[0] <= i_cfg_data;
                smsw_pkg::CFG_CENTER_Y: r_cfg_center[1] <= i_cfg_data;
                smsw_pkg::CFG_CENTER_Z: r_cfg_center[2] <= i_cfg_data;
                smsw_pkg::CFG_RADIUS:   r_cfg_radius    <= i_cfg_data[RW-1:0];
                smsw_pkg::CFG_SHIFT_X:  r_cfg_shift[0]  <= i_cfg_data;
                smsw_pkg::CFG_SHIFT_Y:  r_cfg_shift[1]  <= i_cfg_data;
                smsw_pkg::CFG_SHIFT_Z:  r_cfg_shift[2]  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_r2 <= SQ'(r_cfg_radius) * SQ'(r_cfg_radius);
    end

    // stage 0: magnitudes of the differences
    logic [W-1:0]   in_pos [0:2];
    logic [W-1:0]   n_s0_mag [0:2];
    logic           r_s0_vld;
    logic [W-1:0]   r_s0_mag [0:2];
    logic [3*W-1:0] r_s0_pos;

    assign in_pos[0] = i_pos_x;
    assign in_pos[1] = i_pos_y;
    assign in_pos[2] = i_pos_z;

    always_comb begin
        logic [W:0] diff;
        logic [W:0] mag;
        for (int i = 0; i < 3; i++) begin
            diff = {in_pos[i][W-1], in_pos[i]} - {r_cfg_center[i][W-1], r_cfg_center[i]};
            mag  = diff[W] ? (~diff + (W+1)'(1)) : diff;
            n_s0_mag[i] = mag[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (en) begin
            r_s0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_mag[0] <= n_s0_mag[0];
            r_s0_mag[1] <= n_s0_mag[1];
            r_s0_mag[2] <= n_s0_mag[2];
            r_s0_pos    <= {i_pos_x, i_pos_y, i_pos_z};
        end
    end

    // stage 1: squares
    logic           r_s1_vld;
    logic [2*W-1:0] r_s1_sq [0:2];
    logic [3*W-1:0] r_s1_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= r_s0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_s1_sq[i] <= (2*W)'(r_s0_mag[i]) * (2*W)'(r_s0_mag[i]);
            end
            r_s1_pos <= r_s0_pos;
        end
    end

    // sum, inside test, then one root bit per stage
    logic [SW-1:0]  n_sum;
    logic           n_inside;
    logic           r_sq_vld [0:RW];
    logic           r_sq_in  [0:RW];
    logic [RW+1:0]  r_sq_rem [0:RW];
    logic [RW-1:0]  r_sq_q   [0:RW];
    logic [SQ-1:0]  r_sq_rad [0:RW];
    logic [3*W-1:0] r_sq_pos [0:RW];

    assign n_sum    = SW'(r_s1_sq[0]) + SW'(r_s1_sq[1]) + SW'(r_s1_sq[2]);
    assign n_inside = n_sum < SW'(r_r2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else if (en) begin
            r_sq_vld[0] <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_in[0]  <= n_inside;
            r_sq_rem[0] <= '0;
            r_sq_q[0]   <= '0;
            r_sq_rad[0] <= n_sum[SQ-1:0];
            r_sq_pos[0] <= r_s1_pos;
        end
    end

    for (genvar j = 0; j < RW; j++) begin : g_sqrt
        logic [RW+1:0] trial_rem;
        logic [RW+1:0] trial_sub;
        logic          ge;

        assign trial_rem = {r_sq_rem[j][RW-1:0], r_sq_rad[j][SQ-1 -: 2]};
        assign trial_sub = {r_sq_q[j], 2'b01};
        assign ge        = trial_rem >= trial_sub;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[j+1] <= 1'b0;
            end else if (en) begin
                r_sq_vld[j+1] <= r_sq_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_in[j+1]  <= r_sq_in[j];
                r_sq_rem[j+1] <= ge ? (trial_rem - trial_sub) : trial_rem;
                r_sq_q[j+1]   <= {r_sq_q[j][RW-2:0], ge};
                r_sq_rad[j+1] <= {r_sq_rad[j][SQ-3:0], 2'b00};
                r_sq_pos[j+1] <= r_sq_pos[j];
            end
        end
    end

    // t = (r - d) / r, one quotient bit per stage
    logic [RW-1:0]  n_dv_rem0;
    logic           n_dv_zero;
    logic           r_dv_vld [0:F];
    logic           r_dv_in  [0:F];
    logic [RW-1:0]  r_dv_rem [0:F];
    logic [F:0]     r_dv_t   [0:F];
    logic [3*W-1:0] r_dv_pos [0:F];

    assign n_dv_zero = r_sq_q[RW] == '0;
    assign n_dv_rem0 = r_cfg_radius - r_sq_q[RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (en) begin
            r_dv_vld[0] <= r_sq_vld[RW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_in[0]  <= r_sq_in[RW];
            r_dv_rem[0] <= n_dv_zero ? '0 : n_dv_rem0;
            r_dv_t[0]   <= (F+1)'(n_dv_zero);
            r_dv_pos[0] <= r_sq_pos[RW];
        end
    end

    for (genvar j = 0; j < F; j++) begin : g_div
        logic [W-1:0] rem2;
        logic         ge;
        logic [W-1:0] rem_sub;

        assign rem2    = {r_dv_rem[j], 1'b0};
        assign ge      = rem2 >= {1'b0, r_cfg_radius};
        assign rem_sub = rem2 - {1'b0, r_cfg_radius};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j+1] <= 1'b0;
            end else if (en) begin
                r_dv_vld[j+1] <= r_dv_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_in[j+1]  <= r_dv_in[j];
                r_dv_rem[j+1] <= ge ? rem_sub[RW-1:0] : rem2[RW-1:0];
                r_dv_t[j+1]   <= {r_dv_t[j][F-1:0], ge};
                r_dv_pos[j+1] <= r_dv_pos[j];
            end
        end
    end

    // weight: floor(t*t) and the linear factor
    logic [2*F+1:0] n_m1_tt;
    logic           r_m1_vld;
    logic           r_m1_in;
    logic [F+1:0]   r_m1_tt;
    logic [F+1:0]   r_m1_lin;
    logic [3*W-1:0] r_m1_pos;

    assign n_m1_tt = (2*F+2)'(r_dv_t[F]) * (2*F+2)'(r_dv_t[F]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
        end else if (en) begin
            r_m1_vld <= r_dv_vld[F];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_in  <= r_dv_in[F];
            r_m1_tt  <= n_m1_tt[2*F+1:F];
            r_m1_lin <= THREE_ONE - {r_dv_t[F], 1'b0};
            r_m1_pos <= r_dv_pos[F];
        end
    end

    logic [2*F+3:0] n_m2_prod;
    logic           r_m2_vld;
    logic           r_m2_in;
    logic [F:0]     r_m2_w;
    logic [3*W-1:0] r_m2_pos;

    assign n_m2_prod = (2*F+4)'(r_m1_tt) * (2*F+4)'(r_m1_lin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_vld <= 1'b0;
        end else if (en) begin
            r_m2_vld <= r_m1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m2_in  <= r_m1_in;
            r_m2_w   <= n_m2_prod[2*F:F];
            r_m2_pos <= r_m1_pos;
        end
    end

    // scaled shift, floored
    logic signed [PW-1:0] n_m3_prod [0:2];
    logic                 r_m3_vld;
    logic                 r_m3_in;
    logic [W:0]           r_m3_disp [0:2];
    logic [3*W-1:0]       r_m3_pos;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_m3_prod[i] = signed'({{(F+2){r_cfg_shift[i][W-1]}}, r_cfg_shift[i]})
                         * signed'({{(W+1){1'b0}}, r_m2_w});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m3_vld <= 1'b0;
        end else if (en) begin
            r_m3_vld <= r_m2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m3_in <= r_m2_in;
            for (int i = 0; i < 3; i++) begin
                r_m3_disp[i] <= r_m2_in ? n_m3_prod[i][W+F:F] : '0;
            end
            r_m3_pos <= r_m2_pos;
        end
    end

    // saturating add and output register
    logic [W-1:0]   m3_pos [0:2];
    logic [W-1:0]   n_out  [0:2];
    logic           r_out_vld;
    logic           r_out_moved;
    logic [W-1:0]   r_out  [0:2];

    assign m3_pos[0] = r_m3_pos[3*W-1:2*W];
    assign m3_pos[1] = r_m3_pos[2*W-1:W];
    assign m3_pos[2] = r_m3_pos[W-1:0];

    always_comb begin
        logic signed [W+1:0] sum;
        for (int i = 0; i < 3; i++) begin
            sum = signed'({{2{m3_pos[i][W-1]}}, m3_pos[i]})
                + signed'({r_m3_disp[i][W], r_m3_disp[i]});
            priority if (sum > SAT_MAX) begin
                n_out[i] = SAT_MAX[W-1:0];
            end else if (sum < SAT_MIN) begin
                n_out[i] = SAT_MIN[W-1:0];
            end else begin
                n_out[i] = sum[W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_m3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_moved <= r_m3_in;
            r_out[0]    <= n_out[0];
            r_out[1]    <= n_out[1];
            r_out[2]    <= n_out[2];
        end
    end

    assign o_valid = r_out_vld;
    assign o_moved = r_out_moved;
    assign o_new_x = r_out[0];
    assign o_new_y = r_out[1];
    assign o_new_z = r_out[2];

endmodule

// ===== src/smsw_checker.sv =====
// ----------------------------------------------------------------------------
// smsw_checker
// Port-level checks of the sphere vertex warp, bound to the top level.
// ----------------------------------------------------------------------------
module smsw_checker #(
    parameter int COORD_WIDTH = 32
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_stall,
    input logic                   o_valid,
    input logic                   i_stall,
    input logic [COORD_WIDTH-1:0] o_new_x,
    input logic                   o_moved,
    input logic                   o_cfg_ready
);

    a_stall_follows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow a blocked output transfer");

    a_output_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_new_x) && $stable(o_moved))
        else $error("stalled output changed");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_cfg_always_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

endmodule

bind smoothstep_sphere_vertex_warp smsw_checker #(
    .COORD_WIDTH(COORD_WIDTH)
) u_smsw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_new_x     (o_new_x),
    .o_moved     (o_moved),
    .o_cfg_ready (o_cfg_ready)
);

// ===== tb/sv/smoothstep_sphere_vertex_warp_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// smoothstep_sphere_vertex_warp_test
// Streams vertices through the sphere warp and checks every warped vertex
// against a bit-exact predictor of the distance, smoothstep weight and
// saturating shift. Covers several sphere settings, random idle on both
// channels and one long output hold that backs the pipeline up.
// ----------------------------------------------------------------------------
module smoothstep_sphere_vertex_warp_test;

    localparam int  PIPE_DEPTH  = 55;
    localparam int  CYCLE_LIMIT = 400000;
    localparam longint CMAX     = 64'sd2147483647;
    localparam longint CMIN     = -64'sd2147483648;

    typedef struct {
        logic [31:0] p[3];
    } t_vertex;

    typedef struct {
        logic [31:0] c[3];
        logic        moved;
    } t_warped;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [31:0] i_pos_x = '0;
    logic [31:0] i_pos_y = '0;
    logic [31:0] i_pos_z = '0;
    logic        i_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    smsw_pkg::t_cfg_index i_cfg_index = smsw_pkg::CFG_CENTER_X;
    logic [31:0] i_cfg_data = '0;
    logic        o_stall, o_valid, o_moved, o_cfg_ready;
    logic [31:0] o_new_x, o_new_y, o_new_z;

    smoothstep_sphere_vertex_warp dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_new_x(o_new_x), .o_new_y(o_new_y), .o_new_z(o_new_z), .o_moved(o_moved),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    t_vertex pend_q[$];
    t_warped warp_q[$];
    t_vertex cur_vtx;
    bit      busy = 0;
    bit      quiet = 0;
    bit      jam_on = 0;
    int      gap_cnt = 0;
    int      hold_cnt = 0;
    int      jam_cnt = 0;
    int      jam_req = 0;
    int      jam_done = 0;
    int      errors = 0;
    int      n_in = 0;
    int      n_out = 0;
    int      n_moved = 0;
    int      n_cfg = 0;
    int      cycles = 0;

    longint      ctr[3];
    longint      shf[3];
    logic [63:0] rad;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic t_warped warp_vertex(t_vertex v);
        logic [127:0] ssum, r2, cand;
        logic [63:0]  m, res, rem, t, w;
        longint       pos, dif, prod, s;
        t_warped      o;
        ssum = '0;
        for (int i = 0; i < 3; i++) begin
            pos = longint'($signed(v.p[i]));
            dif = pos - ctr[i];
            m = (dif < 0) ? -dif : dif;
            ssum = ssum + 128'(m) * 128'(m);
        end
        r2 = 128'(rad) * 128'(rad);
        o.moved = (ssum < r2);
        if (o.moved) begin
            res = '0;
            for (int b = 49; b >= 0; b--) begin
                cand = 128'(res | (64'd1 << b));
                if (cand * cand <= ssum) res = cand[63:0];
            end
            rem = rad - res;
            t = '0;
            if (rem >= rad) begin
                t = 1;
                rem = 0;
            end
            for (int i = 0; i < 16; i++) begin
                rem = rem << 1;
                t = t << 1;
                if (rem >= rad) begin
                    rem = rem - rad;
                    t = t | 64'd1;
                end
            end
            w = (((t * t) >> 16) * ((64'd3 << 16) - 2 * t)) >> 16;
        end
        for (int i = 0; i < 3; i++) begin
            pos = longint'($signed(v.p[i]));
            if (o.moved) begin
                prod = shf[i] * longint'(w);
                s = pos + (prod >>> 16);
                if (s > CMAX) s = CMAX;
                if (s < CMIN) s = CMIN;
            end else begin
                s = pos;
            end
            o.c[i] = s[31:0];
        end
        return o;
    endfunction

    // input side: hold payload until transfer, then idle a drawn number of cycles
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                warp_q = {warp_q, warp_vertex(cur_vtx)};
                n_in++;
                busy = 0;
                gap_cnt = quiet ? 0 : $urandom_range(0, 8);
            end
            if (!busy) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                end else if (pend_q.size() > 0) begin
                    cur_vtx = pend_q.pop_front();
                    busy = 1;
                end
            end
            i_valid <= busy;
            if (busy) begin
                i_pos_x <= cur_vtx.p[0];
                i_pos_y <= cur_vtx.p[1];
                i_pos_z <= cur_vtx.p[2];
            end
        end
    end

    // long receiver hold, counted on its own
    always @(posedge i_clk) begin
        if (jam_req != jam_done) begin
            jam_done = jam_req;
            jam_cnt = 400;
        end
        jam_on <= (jam_cnt > 0);
        if (jam_cnt > 0) jam_cnt--;
    end

    // output side: compare each transfer, then stall a drawn number of cycles
    always @(posedge i_clk) begin
        t_warped     exp_w;
        logic [31:0] got[3];
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                n_out++;
                got = '{o_new_x, o_new_y, o_new_z};
                if (warp_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result at cycle %0d", cycles);
                end else begin
                    exp_w = warp_q.pop_front();
                    if (exp_w.moved) n_moved++;
                    for (int i = 0; i < 3; i++) begin
                        if (got[i] !== exp_w.c[i]) begin
                            errors++;
                            if (errors <= 10)
                                $display("result %0d axis %0d: expected %h got %h",
                                         n_out, i, exp_w.c[i], got[i]);
                        end
                    end
                    if (o_moved !== exp_w.moved) begin
                        errors++;
                        if (errors <= 10)
                            $display("result %0d moved: expected %b got %b",
                                     n_out, exp_w.moved, o_moved);
                    end
                end
                hold_cnt = quiet ? 0 : $urandom_range(0, 8);
            end
            i_stall <= (hold_cnt > 0) || jam_on;
            if (hold_cnt > 0) hold_cnt--;
        end
    end

    task automatic write_reg(smsw_pkg::t_cfg_index idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        n_cfg++;
        unique case (idx)
            smsw_pkg::CFG_CENTER_X: ctr[0] = longint'($signed(val));
            smsw_pkg::CFG_CENTER_Y: ctr[1] = longint'($signed(val));
            smsw_pkg::CFG_CENTER_Z: ctr[2] = longint'($signed(val));
            smsw_pkg::CFG_RADIUS:   rad = {33'd0, val[30:0]};
            smsw_pkg::CFG_SHIFT_X:  shf[0] = longint'($signed(val));
            smsw_pkg::CFG_SHIFT_Y:  shf[1] = longint'($signed(val));
            smsw_pkg::CFG_SHIFT_Z:  shf[2] = longint'($signed(val));
            default: ;
        endcase
    endtask

    task automatic setup(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz, logic [31:0] r,
                         logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
        write_reg(smsw_pkg::CFG_CENTER_X, cx);
        write_reg(smsw_pkg::CFG_CENTER_Y, cy);
        write_reg(smsw_pkg::CFG_CENTER_Z, cz);
        write_reg(smsw_pkg::CFG_RADIUS, r);
        write_reg(smsw_pkg::CFG_SHIFT_X, sx);
        write_reg(smsw_pkg::CFG_SHIFT_Y, sy);
        write_reg(smsw_pkg::CFG_SHIFT_Z, sz);
    endtask

    task automatic push(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_vertex v;
        v.p = '{x, y, z};
        pend_q = {pend_q, v};
    endtask

    task automatic settle();
        while (pend_q.size() > 0 || busy || warp_q.size() > 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 5) @(posedge i_clk);
    endtask

    initial begin
        longint      off[3];
        logic [31:0] rsel, span;
        ctr = '{0, 0, 0};
        shf = '{0, 0, 0};
        rad = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // radius zero after reset: everything passes through
        push(32'h7fffffff, 32'h80000000, 32'h0);
        push(32'h0, 32'h0, 32'h0);
        push(32'hffffffff, 32'h1, 32'h80000000);
        settle();

        setup(32'h0, 32'h0, 32'h0, 32'h0010_0000, 32'h7fffffff, 32'h80000000, 32'h0003_8000);
        write_reg(smsw_pkg::t_cfg_index'(smsw_pkg::CFG_SHIFT_Z + 3'd1), 32'hdeadbeef);
        push(32'h0, 32'h0, 32'h0);
        push(32'h0010_0000, 32'h0, 32'h0);
        push(32'h000f_ffff, 32'h0, 32'h0);
        push(32'h0, 32'hfff0_0001, 32'h0);
        push(32'h0008_0000, 32'h0008_0000, 32'h0008_0000);
        push(32'h0020_0000, 32'h0, 32'h0);
        push(32'h0000_0001, 32'hffff_ffff, 32'h0000_0100);
        push(32'h7fffffff, 32'h0, 32'h0);
        settle();

        // saturation near both ends of the range
        setup(32'h7ff0_0000, 32'h8010_0000, 32'h0, 32'h7fffffff,
              32'h7fffffff, 32'h80000000, 32'h80000000);
        push(32'h7fff_0000, 32'h8000_1000, 32'h0);
        push(32'h7fffffff, 32'h80000000, 32'h80000000);
        push(32'h0, 32'h0, 32'h0);
        push(32'h7ff0_0000, 32'h8010_0000, 32'h0);
        settle();

        setup(32'h0, 32'h0, 32'h0, 32'h1, 32'h0001_0000, 32'hffff_0000, 32'h7fffffff);
        push(32'h0, 32'h0, 32'h0);
        push(32'h1, 32'h0, 32'h0);
        push(32'h0, 32'h0, 32'hffffffff);
        settle();

        for (int ph = 0; ph < 9; ph++) begin
            quiet = (ph == 2);
            case ($urandom_range(0, 4))
                0: rsel = 32'h0;
                1: rsel = 32'h7fffffff;
                2: rsel = $urandom_range(1, 64);
                default: rsel = $urandom_range(1, 32'h0400_0000);
            endcase
            setup($urandom, $urandom, $urandom, rsel, $urandom, $urandom, $urandom);
            if (ph == 4) jam_req++;
            span = (rsel == 0) ? 32'h1000 : rsel;
            for (int k = 0; k < 155; k++) begin
                if ($urandom_range(0, 4) == 0) begin
                    push($urandom, $urandom, $urandom);
                end else begin
                    for (int i = 0; i < 3; i++)
                        off[i] = longint'($urandom_range(0, span)) * 2 / 3 - span / 3;
                    push(32'(ctr[0] + off[0]), 32'(ctr[1] + off[1]), 32'(ctr[2] + off[2]));
                end
            end
            settle();
        end

        $display("%0d vertices in, %0d out, %0d moved inside the sphere",
                 n_in, n_out, n_moved);
        $display("%0d register writes over directed and 9 random settings", n_cfg);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
